// ----- sv/phx_pkg.sv -----
// shared constants and types for the philox generator
package phx_pkg;

  localparam int ROUND_COUNT = 10;
  localparam int WORD_W      = 32;
  localparam int KEY_W       = 2 * WORD_W;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [WORD_W-1:0] MUL_A  = 32'hD2511F53;
  localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E8D57;
  localparam logic [WORD_W-1:0] WEYL_A = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] WEYL_B = 32'hBB67AE85;

  localparam logic [CFG_INDEX_W-1:0] REG_SEED_KEY  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT = 8'd1;

  localparam logic [KEY_W-1:0]  SEED_KEY_RESET  = 64'd42;
  localparam logic [WORD_W-1:0] BIN_COUNT_RESET = 32'd1;

  typedef logic [WORD_W-1:0] word_t;

  // four block words plus the round key that travels with them
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t ka;
    word_t kb;
  } block_t;

endpackage

// ----- sv/phx_round_cell.sv -----
// one philox round as a registered cell of the round chain
module phx_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            prev_valid,
  input  phx_pkg::block_t prev_block,
  output logic            valid,
  output phx_pkg::block_t block
);

  logic [2*phx_pkg::WORD_W-1:0] pa;
  logic [2*phx_pkg::WORD_W-1:0] pb;
  phx_pkg::block_t              block_next;

  assign pa = (2*phx_pkg::WORD_W)'(phx_pkg::MUL_A) * (2*phx_pkg::WORD_W)'(prev_block.a);
  assign pb = (2*phx_pkg::WORD_W)'(phx_pkg::MUL_B) * (2*phx_pkg::WORD_W)'(prev_block.c);

  always_comb begin
    block_next.a  = pb[2*phx_pkg::WORD_W-1:phx_pkg::WORD_W] ^ prev_block.b ^ prev_block.ka;
    block_next.b  = pb[phx_pkg::WORD_W-1:0];
    block_next.c  = pa[2*phx_pkg::WORD_W-1:phx_pkg::WORD_W] ^ prev_block.d ^ prev_block.kb;
    block_next.d  = pa[phx_pkg::WORD_W-1:0];
    // key for the following round
    block_next.ka = prev_block.ka + phx_pkg::WEYL_A;
    block_next.kb = prev_block.kb + phx_pkg::WEYL_B;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      block <= block_next;
    end
  end

endmodule

// ----- sv/phx_bin_stage.sv -----
// final cell: range reduction of the four words and the result register
module phx_bin_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         prev_valid,
  input  phx_pkg::block_t              prev_block,
  input  logic [phx_pkg::WORD_W-1:0]   bin_count,
  output logic                         valid,
  output logic [phx_pkg::WORD_W-1:0]   word0,
  output logic [phx_pkg::WORD_W-1:0]   word1,
  output logic [phx_pkg::WORD_W-1:0]   word2,
  output logic [phx_pkg::WORD_W-1:0]   word3,
  output logic [phx_pkg::WORD_W-1:0]   bin0,
  output logic [phx_pkg::WORD_W-1:0]   bin1,
  output logic [phx_pkg::WORD_W-1:0]   bin2,
  output logic [phx_pkg::WORD_W-1:0]   bin3
);

  phx_pkg::word_t               words [4];
  logic [2*phx_pkg::WORD_W-1:0] prod  [4];

  always_comb begin
    words[0] = prev_block.a;
    words[1] = prev_block.b;
    words[2] = prev_block.c;
    words[3] = prev_block.d;
    for (int i = 0; i < 4; i++) begin
      prod[i] = (2*phx_pkg::WORD_W)'(words[i]) * (2*phx_pkg::WORD_W)'(bin_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word0 <= words[0];
      word1 <= words[1];
      word2 <= words[2];
      word3 <= words[3];
      // multiply-high keeps the upper half
      bin0  <= prod[0][2*phx_pkg::WORD_W-1:phx_pkg::WORD_W];
      bin1  <= prod[1][2*phx_pkg::WORD_W-1:phx_pkg::WORD_W];
      bin2  <= prod[2][2*phx_pkg::WORD_W-1:phx_pkg::WORD_W];
      bin3  <= prod[3][2*phx_pkg::WORD_W-1:phx_pkg::WORD_W];
    end
  end

endmodule

// ----- sv/philox_counter_random_generator.sv -----
// philox4x32 generator top level: config registers, round chain, bin stage
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  config   | cfg_valid cfg_ready cfg_index cfg_data    | in
//  item     | item_valid item_ready block_counter       | in
//  result   | result_valid result_ready word0..3 bin0..3| out
//
// one request per cycle unless a stalled result fills the chain; a request passes one cell per round,
// then one cell for the bin multiplies, which also holds the result.
// each cell loads when it is empty or its neighbor loads, so a stalled result
// holds the chain back only once the cells in front of it are full.
// reset clears all valid bits and sets seed_key to 42 and bin_count to 1.
// config writes are always taken.
module philox_counter_random_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [phx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [phx_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic [phx_pkg::KEY_W-1:0]        block_counter,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [phx_pkg::WORD_W-1:0]       word0,
  output logic [phx_pkg::WORD_W-1:0]       word1,
  output logic [phx_pkg::WORD_W-1:0]       word2,
  output logic [phx_pkg::WORD_W-1:0]       word3,
  output logic [phx_pkg::WORD_W-1:0]       bin0,
  output logic [phx_pkg::WORD_W-1:0]       bin1,
  output logic [phx_pkg::WORD_W-1:0]       bin2,
  output logic [phx_pkg::WORD_W-1:0]       bin3
);

  logic [phx_pkg::KEY_W-1:0]    seed_key;
  logic [phx_pkg::WORD_W-1:0]   bin_count;

  logic [phx_pkg::ROUND_COUNT:0] stage_valid;
  logic [phx_pkg::ROUND_COUNT:0] load;
  phx_pkg::block_t               stage_block [phx_pkg::ROUND_COUNT+1];
  phx_pkg::block_t               entry_block;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_key  <= phx_pkg::SEED_KEY_RESET;
      bin_count <= phx_pkg::BIN_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == phx_pkg::REG_SEED_KEY) begin
        seed_key <= cfg_data;
      end else if (cfg_index == phx_pkg::REG_BIN_COUNT) begin
        bin_count <= cfg_data[phx_pkg::WORD_W-1:0];
      end
    end
  end

  // block entering the first round: counter in words 0 and 1, words 2 and 3 zero
  always_comb begin
    entry_block.a  = block_counter[phx_pkg::WORD_W-1:0];
    entry_block.b  = block_counter[phx_pkg::KEY_W-1:phx_pkg::WORD_W];
    entry_block.c  = '0;
    entry_block.d  = '0;
    entry_block.ka = seed_key[phx_pkg::WORD_W-1:0];
    entry_block.kb = seed_key[phx_pkg::KEY_W-1:phx_pkg::WORD_W];
  end

  assign stage_valid[0] = item_valid;
  assign stage_block[0] = entry_block;

  assign load[phx_pkg::ROUND_COUNT] = !result_valid || result_ready;
  assign item_ready                 = load[0];

  for (genvar r = 0; r < phx_pkg::ROUND_COUNT; r++) begin : g_round
    assign load[r] = !stage_valid[r+1] || load[r+1];

    phx_round_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (load[r]),
      .prev_valid (stage_valid[r]),
      .prev_block (stage_block[r]),
      .valid      (stage_valid[r+1]),
      .block      (stage_block[r+1])
    );
  end

  phx_bin_stage u_bin (
    .clk        (clk),
    .rst        (rst),
    .load       (load[phx_pkg::ROUND_COUNT]),
    .prev_valid (stage_valid[phx_pkg::ROUND_COUNT]),
    .prev_block (stage_block[phx_pkg::ROUND_COUNT]),
    .bin_count  (bin_count),
    .valid      (result_valid),
    .word0      (word0),
    .word1      (word1),
    .word2      (word2),
    .word3      (word3),
    .bin0       (bin0),
    .bin1       (bin1),
    .bin2       (bin2),
    .bin3       (bin3)
  );

endmodule
